// ----- design/exclusive_time_profiler_defines.svh -----
// Assertion macros used by the profiler port checker.
`ifndef EXCLUSIVE_TIME_PROFILER_DEFINES_SVH
`define EXCLUSIVE_TIME_PROFILER_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define ETP_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("profiler check failed");

// Next-cycle implication, disabled while dis is high.
`define ETP_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("profiler check failed");

`endif

// ----- design/etp_pkg.sv -----
// Types and codes shared by the exclusive time profiler modules.
package etp_pkg;

  localparam int ID_W = 8;
  localparam int TS_W = 32;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_END   = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NONE      = 2'd1,
    STAT_OVERFLOW  = 2'd2,
    STAT_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stk_op_t;

  // One stack entry: function id and its resume time.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [TS_W-1:0] rs;
  } entry_t;

  // Control handed to the stack each cycle.
  typedef struct packed {
    stk_op_t         op;
    entry_t          new_entry;
    logic [TS_W-1:0] fix_rs;
  } stk_ctrl_t;

endpackage

// ----- design/etp_cell.sv -----
// One stack cell: holds an entry, loads from the neighbor above or below.
module etp_cell (
  input  logic             clk,
  input  etp_pkg::stk_op_t op,
  input  etp_pkg::entry_t  up_in,
  input  etp_pkg::entry_t  dn_in,
  output etp_pkg::entry_t  q
);

  always_ff @(posedge clk) begin
    case (op)
      etp_pkg::STK_PUSH: q <= up_in;
      etp_pkg::STK_POP:  q <= dn_in;
      default:           q <= q;
    endcase
  end

endmodule

// ----- design/etp_stack.sv -----
// Shift-register call stack built from a row of cells, top in cell 0.
module etp_stack #(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk,
  input  etp_pkg::stk_ctrl_t ctrl,
  output etp_pkg::entry_t    top_entry
);

  etp_pkg::entry_t cell_q [STACK_DEPTH];
  etp_pkg::entry_t up_w   [STACK_DEPTH];
  etp_pkg::entry_t dn_w   [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    // The caller's entry moving down on push, or up on pop, takes the fixed resume time.
    if (i == 0) begin : g_up_top
      assign up_w[i] = ctrl.new_entry;
    end else if (i == 1) begin : g_up_caller
      assign up_w[i] = '{id: cell_q[0].id, rs: ctrl.fix_rs};
    end else begin : g_up_mid
      assign up_w[i] = cell_q[i-1];
    end

    if (i == 0) begin : g_dn_top
      assign dn_w[i] = '{id: cell_q[1].id, rs: ctrl.fix_rs};
    end else if (i == STACK_DEPTH - 1) begin : g_dn_last
      assign dn_w[i] = '0;
    end else begin : g_dn_mid
      assign dn_w[i] = cell_q[i+1];
    end

    etp_cell u_cell (
      .clk   (clk),
      .op    (ctrl.op),
      .up_in (up_w[i]),
      .dn_in (dn_w[i]),
      .q     (cell_q[i])
    );
  end

  assign top_entry = cell_q[0];

endmodule

// ----- design/etp_totals.sv -----
// Per-function total RAM: one write port, one registered read port.
module etp_totals #(
  parameter int NUM_FUNCS = 256,
  parameter int AW        = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [NUM_FUNCS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/exclusive_time_profiler.sv -----
// Call-stack profiler that keeps exclusive time per function id.
//
//   channel  dir  handshake                        payload
//   s_axis   in   s_axis_tvalid / s_axis_tready    tuser req_type, tdata func_id, timestamp
//   m_axis   out  m_axis_tvalid / m_axis_tready    tuser status, tdata report_id, total_time
//
// The accept cycle of a request reads the totals RAM and works out the time
// delta; the execute state then adds, writes back and shifts the stack as needed.
// After reset, and after every clear request, a sweep zeroes every entry of the
// totals RAM; s_axis_tready stays low during the sweep.
// The execute cycle waits while the previous result is still held on m_axis.
module exclusive_time_profiler #(
  parameter int NUM_FUNCS   = 256,
  parameter int STACK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func_id [7:0], timestamp [39:8]
  input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // report_id [7:0], total_time [39:8]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int AW  = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_EXEC} state_t;

  state_t            state;
  logic [AW-1:0]     clr_addr;
  logic [SPW-1:0]    sp;

  etp_pkg::req_t     req_kind;
  logic [7:0]        req_id;
  logic [31:0]       req_ts;
  logic [32:0]       req_delta;
  logic [31:0]       req_fix;
  logic              req_id_ok;
  logic [AW-1:0]     req_addr;

  logic              out_valid;
  etp_pkg::status_t  out_status;
  logic [7:0]        out_id;
  logic [31:0]       out_total;

  etp_pkg::req_t     in_kind;
  logic [7:0]        in_id;
  logic [31:0]       in_ts;
  logic              accept;
  logic              can_go;
  logic              exec_fire;

  etp_pkg::entry_t    top_entry;
  etp_pkg::stk_ctrl_t stk_ctrl;

  logic [32:0]       diff;
  logic [32:0]       delta_next;
  logic [31:0]       fix_next;
  logic              id_ok_next;
  logic [AW-1:0]     addr_next;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [31:0]       mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [31:0]       mem_rdata;

  logic [33:0]       sum;
  logic [31:0]       sat_total;

  etp_pkg::stk_op_t  exec_op;
  logic              exec_we;
  etp_pkg::status_t  res_status;
  logic [7:0]        res_id;
  logic [31:0]       res_total;

  assign in_kind = etp_pkg::req_t'(s_axis_tuser);
  assign in_id   = s_axis_tdata[7:0];
  assign in_ts   = s_axis_tdata[39:8];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign can_go        = !out_valid || m_axis_tready;
  assign exec_fire     = (state == ST_EXEC) && can_go;

  // Delta against the current top, taken in the accept cycle.
  assign diff       = {1'b0, in_ts} - {1'b0, top_entry.rs};
  assign delta_next = diff[32] ? 33'd0 : diff + 33'(in_kind == etp_pkg::REQ_END);
  assign fix_next   = (in_kind == etp_pkg::REQ_END && in_ts != MAX32) ? in_ts + 32'd1 : in_ts;
  assign id_ok_next = {24'd0, in_id} < 32'(NUM_FUNCS);
  assign addr_next  = (in_kind == etp_pkg::REQ_QUERY) ? AW'(in_id) : AW'(top_entry.id);

  assign mem_raddr = (state == ST_IDLE) ? addr_next : req_addr;

  assign sum       = {2'b00, mem_rdata} + {1'b0, req_delta};
  assign sat_total = (|sum[33:32]) ? MAX32 : sum[31:0];

  always_comb begin
    exec_op    = etp_pkg::STK_HOLD;
    exec_we    = 1'b0;
    res_status = etp_pkg::STAT_NONE;
    res_id     = '0;
    res_total  = '0;
    case (req_kind)
      etp_pkg::REQ_START: begin
        if (!req_id_ok) begin
          res_status = etp_pkg::STAT_NONE;
        end else if (sp == SPW'(STACK_DEPTH)) begin
          res_status = etp_pkg::STAT_OVERFLOW;
        end else if (sp == '0) begin
          exec_op = etp_pkg::STK_PUSH;
        end else begin
          exec_op    = etp_pkg::STK_PUSH;
          exec_we    = 1'b1;
          res_status = etp_pkg::STAT_OK;
          res_id     = top_entry.id;
          res_total  = sat_total;
        end
      end
      etp_pkg::REQ_END: begin
        if (sp == '0) begin
          res_status = etp_pkg::STAT_UNDERFLOW;
        end else begin
          exec_op    = etp_pkg::STK_POP;
          exec_we    = 1'b1;
          res_status = etp_pkg::STAT_OK;
          res_id     = top_entry.id;
          res_total  = sat_total;
        end
      end
      etp_pkg::REQ_QUERY: begin
        if (req_id_ok) begin
          res_status = etp_pkg::STAT_OK;
          res_id     = req_id;
          res_total  = mem_rdata;
        end
      end
      default: begin
        res_status = etp_pkg::STAT_NONE;
      end
    endcase
  end

  assign stk_ctrl.op        = exec_fire ? exec_op : etp_pkg::STK_HOLD;
  assign stk_ctrl.new_entry = '{id: req_id, rs: req_ts};
  assign stk_ctrl.fix_rs    = req_fix;

  // Sweep owns the write port; otherwise write back the updated total.
  assign mem_we    = (state == ST_SWEEP) || (exec_fire && exec_we);
  assign mem_waddr = (state == ST_SWEEP) ? clr_addr : req_addr;
  assign mem_wdata = (state == ST_SWEEP) ? 32'd0 : sat_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      clr_addr  <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new result as the held one leaves.
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (clr_addr == AW'(NUM_FUNCS - 1)) begin
            clr_addr <= '0;
            state    <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (can_go) begin
            if (req_kind == etp_pkg::REQ_CLEAR) begin
              sp    <= '0;
              state <= ST_SWEEP;
            end else begin
              state <= ST_IDLE;
              if (exec_op == etp_pkg::STK_PUSH) begin
                sp <= sp + SPW'(1);
              end else if (exec_op == etp_pkg::STK_POP) begin
                sp <= sp - SPW'(1);
              end
            end
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind  <= in_kind;
      req_id    <= in_id;
      req_ts    <= in_ts;
      req_delta <= delta_next;
      req_fix   <= fix_next;
      req_id_ok <= id_ok_next;
      req_addr  <= addr_next;
    end
    if (exec_fire) begin
      out_status <= res_status;
      out_id     <= res_id;
      out_total  <= res_total;
    end
  end

  etp_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk       (clk),
    .ctrl      (stk_ctrl),
    .top_entry (top_entry)
  );

  etp_totals #(
    .NUM_FUNCS (NUM_FUNCS),
    .AW        (AW)
  ) u_totals (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = {out_total, out_id};

endmodule

// ----- design/etp_chk.sv -----
// Port-level checker for the exclusive time profiler, bound to the top level.
`include "exclusive_time_profiler_defines.svh"

module etp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  logic        in_fire;
  logic        out_stall;
  logic        no_report;
  logic [41:0] out_word;

  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign no_report = m_axis_tvalid && (m_axis_tuser != etp_pkg::STAT_OK);
  assign out_word  = {m_axis_tuser, m_axis_tdata};

  // Only a reported total carries an id and a time.
  `ETP_ASSERT_SAME(a_zero_payload, clk, rst, no_report, m_axis_tdata == 40'd0)
  // No request is accepted directly after another.
  `ETP_ASSERT_NEXT(a_no_back_to_back, clk, rst, in_fire, !s_axis_tready)
  // Reset leaves no result pending and the input not ready.
  `ETP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid && !s_axis_tready)
  // A stalled result holds.
  `ETP_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind exclusive_time_profiler etp_chk u_etp_chk (.*);

// ----- tb/etp_time_checker.sv -----
// Predicts each profiler report from the accepted requests and compares it with the block's output.
module etp_time_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // func_id [7:0], timestamp [39:8]
  input  logic [1:0]  s_axis_tuser,   // req_type [1:0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // report_id [7:0], total_time [39:8]
  input  logic [1:0]  m_axis_tuser,   // status [1:0]
  output int          failures,
  output int          pending,
  output int          compared
);

  localparam int          FUNCS    = 256;
  localparam int          DEPTH    = 256;
  localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    etp_pkg::status_t status;
    logic [7:0]       id;
    logic [31:0]      total;
  } report_t;

  logic [7:0]  frame_id     [DEPTH];
  logic [31:0] frame_resume [DEPTH];
  int unsigned frames = 0;
  logic [31:0] excl_time    [FUNCS];

  report_t owed_reports [$];
  report_t want;
  report_t got;
  int      errs    = 0;
  int      checked = 0;

  function automatic logic [31:0] credit(logic [31:0] acc, logic [32:0] delta);
    logic [33:0] sum;
    sum = {2'b00, acc} + {1'b0, delta};
    return (sum > {2'b00, TICK_MAX}) ? TICK_MAX : sum[31:0];
  endfunction

  // Apply one request to the shadow stack and totals; return the report it causes.
  function automatic report_t account_event(etp_pkg::req_t kind, logic [7:0] fid,
                                            logic [31:0] ts);
    report_t     r;
    int unsigned top;
    logic [7:0]  cid;
    logic [32:0] delta;
    r.status = etp_pkg::STAT_NONE;
    r.id     = '0;
    r.total  = '0;
    case (kind)
      etp_pkg::REQ_START: begin
        // func_id is 8 bits wide, so it never reaches the table size
        if (frames >= DEPTH) begin
          r.status = etp_pkg::STAT_OVERFLOW;
        end else if (frames == 0) begin
          frame_id[0]     = fid;
          frame_resume[0] = ts;
          frames          = 1;
        end else begin
          top   = frames - 1;
          cid   = frame_id[top];
          delta = (ts >= frame_resume[top]) ? {1'b0, ts - frame_resume[top]} : '0;
          excl_time[cid]       = credit(excl_time[cid], delta);
          frame_resume[top]    = ts;
          frame_id[frames]     = fid;
          frame_resume[frames] = ts;
          frames++;
          r.status = etp_pkg::STAT_OK;
          r.id     = cid;
          r.total  = excl_time[cid];
        end
      end
      etp_pkg::REQ_END: begin
        if (frames == 0) begin
          r.status = etp_pkg::STAT_UNDERFLOW;
        end else begin
          top   = frames - 1;
          cid   = frame_id[top];
          delta = (ts >= frame_resume[top]) ? {1'b0, ts - frame_resume[top]} + 33'd1 : '0;
          excl_time[cid] = credit(excl_time[cid], delta);
          frames         = top;
          // caller resumes one tick after the callee ends
          if (top > 0)
            frame_resume[top-1] = (ts == TICK_MAX) ? TICK_MAX : ts + 32'd1;
          r.status = etp_pkg::STAT_OK;
          r.id     = cid;
          r.total  = excl_time[cid];
        end
      end
      etp_pkg::REQ_QUERY: begin
        r.status = etp_pkg::STAT_OK;
        r.id     = fid;
        r.total  = excl_time[fid];
      end
      default: begin
        frames = 0;
        foreach (excl_time[i]) excl_time[i] = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frames = 0;
      foreach (excl_time[i]) excl_time[i] = '0;
      owed_reports.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        owed_reports.push_back(account_event(etp_pkg::req_t'(s_axis_tuser),
                                             s_axis_tdata[7:0], s_axis_tdata[39:8]));
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = etp_pkg::status_t'(m_axis_tuser);
        got.id     = m_axis_tdata[7:0];
        got.total  = m_axis_tdata[39:8];
        if (owed_reports.size() == 0) begin
          $error("report with no request outstanding: status %0d id %0d total %0d",
                 got.status, got.id, got.total);
          errs++;
        end else begin
          want = owed_reports.pop_front();
          checked++;
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errs++;
          end
          if (got.id !== want.id) begin
            $error("report_id: expected %0d, got %0d", want.id, got.id);
            errs++;
          end
          if (got.total !== want.total) begin
            $error("total_time: expected %0d, got %0d", want.total, got.total);
            errs++;
          end
        end
      end
    end
    failures <= errs;
    pending  <= owed_reports.size();
    compared <= checked;
  end

endmodule

// ----- tb/testbench.sv -----
// Drives call-stack profiler requests into the block and reports the verdict.
module testbench;

  localparam int STACK_SLOTS = 256;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 900;
  localparam int CALM_AFTER  = 780;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // func_id [7:0], timestamp [39:8]
  logic [1:0]  s_axis_tuser  = '0;   // req_type [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // report_id [7:0], total_time [39:8]
  logic [1:0]  m_axis_tuser;         // status [1:0]

  logic        idle_on     = 1'b0;
  int          failures;
  int          pending;
  int          compared;
  int          cycles      = 0;
  int          stall_left  = 0;
  int          sent        = 0;
  int          req_count [4] = '{default: 0};
  int          stack_level = 0;
  int          deepest     = 0;
  logic [31:0] now         = '0;

  always #6 clk = ~clk;

  exclusive_time_profiler uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  etp_time_checker audit (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .failures      (failures),
    .pending       (pending),
    .compared      (compared)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall at random while idling is enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left    <= $urandom_range(1, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Present one request and hold it until accepted; valid stays high afterwards.
  task automatic send_req(input etp_pkg::req_t kind, input logic [7:0] fid,
                          input logic [31:0] ts);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {ts, fid};
    do @(posedge clk); while (!s_axis_tready);
    sent++;
    req_count[int'(kind)]++;
    case (kind)
      etp_pkg::REQ_START: if (stack_level < STACK_SLOTS) stack_level++;
      etp_pkg::REQ_END:   if (stack_level > 0) stack_level--;
      etp_pkg::REQ_CLEAR: stack_level = 0;
      default:            ;
    endcase
    if (stack_level > deepest) deepest = stack_level;
  endtask

  // Drop valid and wait until every outstanding report has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Nested calls with random ids and times, some stray requests, then unwind.
  task automatic call_episode();
    int target;
    int steps;
    int roll;
    target = $urandom_range(1, 8);
    steps  = $urandom_range(4, 30);
    if ($urandom_range(0, 5) == 0) now = now + $urandom;
    for (int i = 0; i < steps; i++) begin
      roll = $urandom_range(0, 99);
      now  = now + $urandom_range(0, 9);
      if (roll < 5)
        send_req(etp_pkg::req_t'($urandom_range(0, 3)), 8'($urandom),
                 now - $urandom_range(0, 40));
      else if (roll < 15)
        send_req(etp_pkg::REQ_QUERY, 8'($urandom), now);
      else if (stack_level == 0 || (stack_level < target && roll < 60))
        send_req(etp_pkg::REQ_START, 8'($urandom), now);
      else
        send_req(etp_pkg::REQ_END, 8'($urandom), now);
    end
    while (stack_level > 0) begin
      now = now + $urandom_range(0, 9);
      send_req(etp_pkg::REQ_END, 8'($urandom), now);
    end
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      send_req(etp_pkg::REQ_CLEAR, 8'($urandom), $urandom);
      now = $urandom;
    end else if (roll < 35) begin
      send_req(etp_pkg::REQ_END, 8'($urandom), now);
    end
  endtask

  // Fill the stack to the top, push past it, then unwind below empty.
  task automatic deep_fill();
    while (stack_level < STACK_SLOTS) begin
      now = now + $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0)
        send_req(etp_pkg::REQ_QUERY, 8'($urandom), now);
      else
        send_req(etp_pkg::REQ_START, 8'($urandom), now);
    end
    repeat (2) send_req(etp_pkg::REQ_START, 8'($urandom), now + $urandom_range(0, 5));
    while (stack_level > 0) begin
      now = now + $urandom_range(0, 5);
      send_req(etp_pkg::REQ_END, 8'($urandom), now);
    end
    send_req(etp_pkg::REQ_END, 8'($urandom), now);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_req(etp_pkg::REQ_END,   8'h00, 32'd0);            // pop from empty stack
    send_req(etp_pkg::REQ_QUERY, 8'h00, 32'd0);
    send_req(etp_pkg::REQ_QUERY, 8'hFF, 32'd0);
    send_req(etp_pkg::REQ_START, 8'hFF, 32'd0);            // first push, nothing credited
    send_req(etp_pkg::REQ_START, 8'h00, 32'd10);
    send_req(etp_pkg::REQ_END,   8'h5A, 32'd14);
    send_req(etp_pkg::REQ_START, 8'hAA, 32'd12);           // earlier than caller's resume time
    send_req(etp_pkg::REQ_END,   8'h00, 32'h7FFF_FFFF);
    send_req(etp_pkg::REQ_START, 8'h55, 32'hFFFF_FFF0);
    send_req(etp_pkg::REQ_END,   8'h00, 32'hFFFF_FFFF);    // caller resume time pinned at max
    send_req(etp_pkg::REQ_END,   8'h00, 32'hFFFF_FFFF);
    send_req(etp_pkg::REQ_START, 8'h01, 32'd0);
    send_req(etp_pkg::REQ_END,   8'hFF, 32'hFFFF_FFFF);    // total pinned at max
    send_req(etp_pkg::REQ_START, 8'h01, 32'd3);
    send_req(etp_pkg::REQ_END,   8'h00, 32'd9);
    send_req(etp_pkg::REQ_QUERY, 8'h01, 32'd9);
    send_req(etp_pkg::REQ_QUERY, 8'hAA, 32'd9);
    send_req(etp_pkg::REQ_START, 8'h07, 32'd20);
    send_req(etp_pkg::REQ_CLEAR, 8'hC3, 32'hA5A5_A5A5);    // clear with a live stack
    send_req(etp_pkg::REQ_QUERY, 8'h01, 32'd30);
    send_req(etp_pkg::REQ_END,   8'h00, 32'd31);
    now = 32'd40;

    for (int ep = 0; sent < ITEM_TARGET; ep++) begin
      if (sent >= CALM_AFTER)
        idle_on <= 1'b0;
      else
        idle_on <= ($urandom_range(0, 3) != 0);
      if (ep == 4)
        deep_fill();
      else
        call_episode();
      if (ep == 2) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Sent %0d requests: %0d start, %0d end, %0d query, %0d clear.",
             sent, req_count[0], req_count[1], req_count[2], req_count[3]);
    $display("Compared %0d reports; stack reached depth %0d.", compared, deepest);
    if (failures == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
